>>> design/mm_pkg.sv
// shared types, constants and helper functions for the matrix multiplier
`default_nettype none
package mm_pkg;

	localparam int MAX_DIM   = 8;
	localparam int IDX_W     = $clog2(MAX_DIM);
	localparam int ADDR_W    = $clog2(MAX_DIM * MAX_DIM);
	localparam int DIM_W     = 4;
	localparam int FLD_IDX_W = 3;
	localparam int ELEM_W    = 16;
	localparam int MUL_W     = 2 * ELEM_W;
	localparam int PROD_W    = 35;
	localparam int IN_W      = 24;
	localparam int OUT_W     = 48;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [1:0] {
		CMD_WR_A    = 2'd0,
		CMD_WR_B    = 2'd1,
		CMD_COMPUTE = 2'd2
	} cmd_t;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

	// control travelling alongside the store read data
	typedef struct packed {
		logic valid;
		logic first;
	} mac_ctrl_t;

	typedef struct packed {
		logic busy;
	} mac_stat_t;

	function automatic logic [ADDR_W-1:0] st_addr(input logic [IDX_W-1:0] row,
		input logic [IDX_W-1:0] col);
		st_addr = ADDR_W'(int'(row) * MAX_DIM + int'(col));
	endfunction

	// last usable index of a dimension; zero counts as one, large values clamp
	function automatic logic [IDX_W-1:0] eff_last(input logic [DIM_W-1:0] v);
		if (v == '0) begin
			eff_last = '0;
		end else if (int'(v) > MAX_DIM) begin
			eff_last = IDX_W'(MAX_DIM - 1);
		end else begin
			eff_last = IDX_W'(int'(v) - 1);
		end
	endfunction

endpackage
`default_nettype wire

>>> design/mm_store.sv
// element store: one write port, one read port with registered read data
`default_nettype none
module mm_store (
	input  wire logic                      clk,
	input  wire logic                      wr_en,
	input  wire logic [mm_pkg::ADDR_W-1:0] wr_addr,
	input  wire logic [mm_pkg::ELEM_W-1:0] wr_data,
	input  wire logic [mm_pkg::ADDR_W-1:0] rd_addr,
	output logic      [mm_pkg::ELEM_W-1:0] rd_data
);
	import mm_pkg::*;

	logic [ELEM_W-1:0] mem_q [MAX_DIM*MAX_DIM];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule
`default_nettype wire

>>> design/mm_mac.sv
// shared multiply-accumulate unit: registered product, then accumulate
`default_nettype none
module mm_mac (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire mm_pkg::mac_ctrl_t         ctrl,
	input  wire logic [mm_pkg::ELEM_W-1:0] a_data,
	input  wire logic [mm_pkg::ELEM_W-1:0] b_data,
	output mm_pkg::mac_stat_t              stat,
	output logic signed [mm_pkg::PROD_W-1:0] acc
);
	import mm_pkg::*;

	logic signed [MUL_W-1:0]  prod_s2;
	logic                     valid_s2;
	logic                     first_s2;
	logic signed [PROD_W-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			first_s2 <= 1'b0;
		end else begin
			valid_s2 <= ctrl.valid;
			first_s2 <= ctrl.first;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= $signed(a_data) * $signed(b_data);
	end

	// first term of an element restarts the sum
	always_ff @(posedge clk) begin
		if (valid_s2) begin
			if (first_s2) begin
				acc_q <= PROD_W'(prod_s2);
			end else begin
				acc_q <= acc_q + PROD_W'(prod_s2);
			end
		end
	end

	assign stat.busy = valid_s2;
	assign acc       = acc_q;

endmodule
`default_nettype wire

>>> design/matrix_multiply.sv
// Signed 16-bit matrix multiplier. Load transactions write one element of A or B into
// the on-chip stores and are accepted back to back while idle. A compute transaction
// streams out every element of A*B in row-major order, tlast on the final one. One
// multiply-accumulate unit is shared: each product element needs one store read per
// term, then the product and accumulate registers drain, and the output register may
// wait on m_tready. The input side is not ready while a compute is running.
`default_nettype none
module matrix_multiply (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	// cmd[1:0], row_index[4:2], col_index[7:5], element[23:8]
	input  wire logic [mm_pkg::IN_W-1:0]      s_tdata,
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	// out_row[2:0], out_col[5:3], product[40:6], zero fill above
	output logic [mm_pkg::OUT_W-1:0]          m_tdata,
	output logic                              m_tlast,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [mm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [mm_pkg::DIM_W-1:0]     cfg_data
);
	import mm_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_OUT   = 4'b1000
	} state_t;

	state_t state_q;

	logic [DIM_W-1:0] rows_a_q, inner_dim_q, cols_b_q;
	logic [IDX_W-1:0] nr_last, nk_last, nc_last;
	logic [IDX_W-1:0] i_q, j_q, k_q;

	logic [1:0]            in_cmd;
	logic [FLD_IDX_W-1:0]  in_row, in_col;
	logic [ELEM_W-1:0]     in_elem;
	logic                  in_acc, in_ok;
	logic [ADDR_W-1:0]     wr_addr;
	logic                  wr_a, wr_b;

	logic [ELEM_W-1:0] a_rd, b_rd;
	mac_ctrl_t         ctrl_s1_q;
	mac_stat_t         mac_stat;
	logic signed [PROD_W-1:0] acc;

	logic                 out_valid_q, out_last_q;
	logic [FLD_IDX_W-1:0] out_row_q, out_col_q;
	logic [PROD_W-1:0]    out_prod_q;
	logic                 out_load, elem_last;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q    <= DIM_W'(MAX_DIM);
			inner_dim_q <= DIM_W'(MAX_DIM);
			cols_b_q    <= DIM_W'(MAX_DIM);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ROWS_A:    rows_a_q    <= cfg_data;
				REG_INNER_DIM: inner_dim_q <= cfg_data;
				REG_COLS_B:    cols_b_q    <= cfg_data;
				default:       ;
			endcase
		end
	end

	assign nr_last = eff_last(rows_a_q);
	assign nk_last = eff_last(inner_dim_q);
	assign nc_last = eff_last(cols_b_q);

	// input side
	assign in_cmd  = s_tdata[1:0];
	assign in_row  = s_tdata[4:2];
	assign in_col  = s_tdata[7:5];
	assign in_elem = s_tdata[23:8];

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign in_ok    = (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);
	assign wr_addr  = st_addr(IDX_W'(in_row), IDX_W'(in_col));
	assign wr_a     = in_acc && in_ok && (in_cmd == CMD_WR_A);
	assign wr_b     = in_acc && in_ok && (in_cmd == CMD_WR_B);

	mm_store u_store_a (
		.clk     (clk),
		.wr_en   (wr_a),
		.wr_addr (wr_addr),
		.wr_data (in_elem),
		.rd_addr (st_addr(i_q, k_q)),
		.rd_data (a_rd)
	);

	mm_store u_store_b (
		.clk     (clk),
		.wr_en   (wr_b),
		.wr_addr (wr_addr),
		.wr_data (in_elem),
		.rd_addr (st_addr(k_q, j_q)),
		.rd_data (b_rd)
	);

	mm_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl_s1_q),
		.a_data (a_rd),
		.b_data (b_rd),
		.stat   (mac_stat),
		.acc    (acc)
	);

	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || m_tready);
	assign elem_last = (i_q == nr_last) && (j_q == nc_last);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			i_q       <= '0;
			j_q       <= '0;
			k_q       <= '0;
			ctrl_s1_q <= '0;
		end else begin
			ctrl_s1_q.valid <= (state_q == ST_RUN);
			ctrl_s1_q.first <= (state_q == ST_RUN) && (k_q == '0);
			case (state_q)
				ST_IDLE: begin
					if (in_acc && in_cmd == CMD_COMPUTE) begin
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (k_q == nk_last) begin
						k_q     <= '0;
						state_q <= ST_DRAIN;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					// final term is summed at this edge
					if (!ctrl_s1_q.valid && mac_stat.busy) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						if (elem_last) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_RUN;
							if (j_q == nc_last) begin
								j_q <= '0;
								i_q <= i_q + 1'b1;
							end else begin
								j_q <= j_q + 1'b1;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_row_q  <= FLD_IDX_W'(i_q);
			out_col_q  <= FLD_IDX_W'(j_q);
			out_prod_q <= acc;
			out_last_q <= elem_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {(OUT_W - PROD_W - 2 * FLD_IDX_W)'(0), out_prod_q, out_col_q, out_row_q};

	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (k_q <= nk_last))
		else $error("inner counter beyond configured size");

	a_compute_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_cmd == CMD_COMPUTE) |=> (state_q == ST_RUN))
		else $error("compute transaction did not start the sequencer");

	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!ctrl_s1_q.valid && !mac_stat.busy))
		else $error("result taken while terms still in flight");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && elem_last) |=> (state_q == ST_IDLE && m_tvalid && m_tlast))
		else $error("final element did not end the run");

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// testbench for matrix_multiply: randomised load/compute stream checked against an in-bench predictor
`default_nettype none
module tb_top;
	import mm_pkg::*;

	localparam logic [1:0] CMD_NOP = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int IDLE_PCT = 29;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 24;
	localparam int PHASE_ITEMS = 8;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [FLD_IDX_W-1:0] row;
		logic [FLD_IDX_W-1:0] col;
		logic signed [PROD_W-1:0] sum;
		logic last;
	} prod_elem_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DIM_W-1:0] cfg_data = '0;

	// predictor state
	logic [DIM_W-1:0] rows_cfg = 4'd8;
	logic [DIM_W-1:0] inner_cfg = 4'd8;
	logic [DIM_W-1:0] cols_cfg = 4'd8;
	logic signed [ELEM_W-1:0] a_mem [MAX_DIM*MAX_DIM];
	logic signed [ELEM_W-1:0] b_mem [MAX_DIM*MAX_DIM];

	// what the stimulus has loaded so far, so that no unwritten entry is ever read
	bit a_loaded [MAX_DIM*MAX_DIM];
	bit b_loaded [MAX_DIM*MAX_DIM];

	logic [IN_W-1:0] cmd_q [$];
	prod_elem_t product_q [$];
	int bad_cnt = 0;
	int item_cnt = 0;
	int hold_cnt = 0;
	int cycle_cnt = 0;
	logic no_idle = 1'b0;
	logic hold_arm = 1'b0;

	matrix_multiply u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// zero means one, anything above the store size means the full size
	function automatic int dim_eff(input logic [DIM_W-1:0] v);
		if (v == '0) return 1;
		if (int'(v) > MAX_DIM) return MAX_DIM;
		return int'(v);
	endfunction

	function automatic void matmul_step(input logic [IN_W-1:0] d);
		logic [1:0] cmd;
		logic [FLD_IDX_W-1:0] r;
		logic [FLD_IDX_W-1:0] c;
		logic signed [ELEM_W-1:0] e;
		int nr;
		int nk;
		int nc;
		longint acc;
		prod_elem_t p;
		cmd = d[1:0];
		r = d[4:2];
		c = d[7:5];
		e = d[23:8];
		if (cmd == CMD_WR_A) begin
			a_mem[{r, c}] = e;
		end else if (cmd == CMD_WR_B) begin
			b_mem[{r, c}] = e;
		end else if (cmd == CMD_COMPUTE) begin
			nr = dim_eff(rows_cfg);
			nk = dim_eff(inner_cfg);
			nc = dim_eff(cols_cfg);
			for (int i = 0; i < nr; i++) begin
				for (int j = 0; j < nc; j++) begin
					acc = 0;
					for (int k = 0; k < nk; k++)
						acc += longint'(a_mem[i*MAX_DIM+k]) * longint'(b_mem[k*MAX_DIM+j]);
					p.row = FLD_IDX_W'(i);
					p.col = FLD_IDX_W'(j);
					p.sum = acc[PROD_W-1:0];
					p.last = (i == nr - 1) && (j == nc - 1);
					product_q.insert(product_q.size(), p);
				end
			end
		end
	endfunction

	// sender: presents queued items, idles at random between them
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready)
				matmul_step(s_tdata);
			if (!s_tvalid || s_tready) begin
				if (cmd_q.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
					s_tdata <= cmd_q.pop_front();
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks each result transaction, stalls at random and once for a long stretch
	always @(posedge clk or negedge arst_n) begin
		prod_elem_t want;
		prod_elem_t got;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.row = m_tdata[2:0];
				got.col = m_tdata[5:3];
				got.sum = m_tdata[40:6];
				got.last = m_tlast;
				if (product_q.size() == 0) begin
					bad_cnt++;
					if (bad_cnt <= 10)
						$display("unexpected result: row %0d col %0d product %0d last %0b",
							got.row, got.col, got.sum, got.last);
				end else begin
					want = product_q.pop_front();
					if (got != want) begin
						bad_cnt++;
						if (bad_cnt <= 10)
							$display({"mismatch: expected row %0d col %0d product %0d last %0b,",
								" got row %0d col %0d product %0d last %0b"},
								want.row, want.col, want.sum, want.last,
								got.row, got.col, got.sum, got.last);
					end
				end
			end
			if (hold_arm && hold_cnt < HOLD_CYCLES) begin
				hold_cnt++;
				m_tready <= 1'b0;
			end else begin
				m_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("status: fail");
		$finish;
	end

	function automatic logic signed [ELEM_W-1:0] rand_elem();
		int p;
		p = $urandom_range(0, 99);
		if (p < 10) return 16'sh8000;
		if (p < 20) return 16'sh7fff;
		return ELEM_W'($urandom);
	endfunction

	function automatic logic [DIM_W-1:0] rand_dim();
		int p;
		p = $urandom_range(0, 99);
		if (p < 10) return DIM_W'($urandom_range(9, 15));
		if (p < 20) return '0;
		if (p < 30) return 4'd8;
		return DIM_W'($urandom_range(1, 4));
	endfunction

	task automatic push_item(input logic [1:0] cmd, input int r, input int c,
		input logic signed [ELEM_W-1:0] e);
		cmd_q.insert(cmd_q.size(), {e, FLD_IDX_W'(c), FLD_IDX_W'(r), cmd});
		if (cmd == CMD_WR_A) a_loaded[r*MAX_DIM+c] = 1'b1;
		if (cmd == CMD_WR_B) b_loaded[r*MAX_DIM+c] = 1'b1;
		if (cmd != CMD_NOP) item_cnt++;
	endtask

	// fills in whatever the current sizes read but nothing has written, then computes
	task automatic push_compute();
		int nr;
		int nk;
		int nc;
		nr = dim_eff(rows_cfg);
		nk = dim_eff(inner_cfg);
		nc = dim_eff(cols_cfg);
		for (int i = 0; i < nr; i++)
			for (int k = 0; k < nk; k++)
				if (!a_loaded[i*MAX_DIM+k]) push_item(CMD_WR_A, i, k, rand_elem());
		for (int k = 0; k < nk; k++)
			for (int j = 0; j < nc; j++)
				if (!b_loaded[k*MAX_DIM+j]) push_item(CMD_WR_B, k, j, rand_elem());
		push_item(CMD_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7), ELEM_W'($urandom));
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_ROWS_A) rows_cfg = val;
		else if (idx == REG_INNER_DIM) inner_cfg = val;
		else if (idx == REG_COLS_B) cols_cfg = val;
		cfg_valid <= 1'b0;
	endtask

	// sampled away from the rising edge so the sender's pop and drive have settled
	task automatic wait_idle();
		do @(negedge clk); while (cmd_q.size() != 0 || s_tvalid || product_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [DIM_W-1:0] dr;
		logic [DIM_W-1:0] dk;
		logic [DIM_W-1:0] dc;
		int nr;
		int nk;
		int nc;
		int n;
		logic [1:0] ld;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// one row by eight by one column, written as zero and fifteen
		write_reg(REG_ROWS_A, 4'd0);
		write_reg(REG_INNER_DIM, 4'd15);
		write_reg(REG_COLS_B, 4'd0);
		for (int k = 0; k < MAX_DIM; k++) push_item(CMD_WR_A, 0, k, 16'sh7fff);
		for (int k = 0; k < MAX_DIM; k++) push_item(CMD_WR_B, k, 0, 16'sh8000);
		push_compute();
		push_item(CMD_NOP, 7, 7, 16'sh5a5a);
		for (int k = 0; k < MAX_DIM; k++) push_item(CMD_WR_A, 0, k, 16'sh8000);
		push_compute();

		for (int p = 0; p < 8; p++) begin
			wait_idle();
			no_idle <= (p == 4);
			if (p == 2) hold_arm <= 1'b1;
			if (p == 3) write_reg(REG_UNUSED, DIM_W'($urandom));
			if (p == 0) begin
				dr = 4'd1;
				dk = 4'd1;
				dc = 4'd1;
			end else if (p == 2) begin
				dr = 4'd8;
				dk = 4'd1;
				dc = 4'd8;
			end else if (p == 7) begin
				dr = 4'd8;
				dk = 4'd8;
				dc = 4'd15;
			end else begin
				dr = rand_dim();
				dk = rand_dim();
				dc = rand_dim();
			end
			write_reg(REG_ROWS_A, dr);
			write_reg(REG_INNER_DIM, dk);
			write_reg(REG_COLS_B, dc);
			nr = dim_eff(rows_cfg);
			nk = dim_eff(inner_cfg);
			nc = dim_eff(cols_cfg);
			item_cnt = 0;
			while (item_cnt < PHASE_ITEMS) begin
				if ($urandom_range(0, 99) < 70) begin
					// a few loads inside the configured sizes, then a compute
					n = $urandom_range(0, 4);
					repeat (n) begin
						if ($urandom_range(0, 1) == 0)
							push_item(CMD_WR_A, $urandom_range(0, nr - 1),
								$urandom_range(0, nk - 1), rand_elem());
						else
							push_item(CMD_WR_B, $urandom_range(0, nk - 1),
								$urandom_range(0, nc - 1), rand_elem());
					end
					push_compute();
				end else if ($urandom_range(0, 3) == 0) begin
					push_item(CMD_NOP, $urandom_range(0, 7), $urandom_range(0, 7),
						ELEM_W'($urandom));
				end else begin
					ld = ($urandom_range(0, 1) == 0) ? CMD_WR_A : CMD_WR_B;
					push_item(ld, $urandom_range(0, 7), $urandom_range(0, 7), rand_elem());
				end
			end
		end

		wait_idle();
		if (bad_cnt == 0 && product_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
`default_nettype wire
